// File: rtl/irlc_pkg.sv
// Shared types, constants and the color table of the IR-code RGB lamp control.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package irlc_pkg;

	localparam int CODE_W  = 32;
	localparam int PCT_W   = 7;
	localparam int CHAN_W  = 8;
	localparam int PROD_W  = CHAN_W + PCT_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_CODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CODE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_MID     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_HIGH    = 3'd5;

	localparam logic [CODE_W-1:0] TOGGLE_CODE_RST = 32'd551505585;
	localparam logic [CODE_W-1:0] COLOR_CODE_RST  = 32'd551521905;
	localparam logic [CODE_W-1:0] LEVEL_CODE_RST  = 32'd551519865;
	localparam logic [PCT_W-1:0]  PCT_LOW_RST     = 7'd20;
	localparam logic [PCT_W-1:0]  PCT_MID_RST     = 7'd50;
	localparam logic [PCT_W-1:0]  PCT_HIGH_RST    = 7'd80;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**PROD_W.
	localparam int RECIP_W = 17;
	localparam logic [RECIP_W-1:0] RECIP_100 = 17'd41944;
	localparam int RECIP_SHIFT = 22;
	localparam int QUOT_W = 9;
	localparam logic [QUOT_W-1:0] CHAN_MAX = 9'd255;

	typedef struct packed {
		logic [CODE_W-1:0] toggle_code;
		logic [CODE_W-1:0] color_code;
		logic [CODE_W-1:0] level_code;
		logic [PCT_W-1:0]  pct_low;
		logic [PCT_W-1:0]  pct_mid;
		logic [PCT_W-1:0]  pct_high;
	} cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// Snapshot of the lamp after one code, handed to the scaling pipe.
	typedef struct packed {
		logic             power;
		rgb_t             base;
		logic [PCT_W-1:0] pct;
	} scale_req_t;

	// White, red, orange, yellow, pink, blue; the two spare entries are dark.
	function automatic rgb_t color_rgb(input logic [2:0] idx);
		rgb_t c;
		unique case (idx)
			3'd0: c = '{8'd255, 8'd255, 8'd255};
			3'd1: c = '{8'd255, 8'd0,   8'd0};
			3'd2: c = '{8'd255, 8'd100, 8'd0};
			3'd3: c = '{8'd255, 8'd230, 8'd0};
			3'd4: c = '{8'd255, 8'd0,   8'd230};
			3'd5: c = '{8'd0,   8'd0,   8'd255};
			default: c = '{8'd0, 8'd0, 8'd0};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/irlc_if.sv
// Channel interfaces of the IR-code RGB lamp control: code input, lamp result, config writes.
// Depends on irlc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface irlc_code_if import irlc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] ir_code;

	modport source (output valid, output ir_code, input ready);
	modport sink   (input valid, input ir_code, output ready);
endinterface

interface irlc_lamp_if import irlc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              lamp_on;
	logic [CHAN_W-1:0] red_level;
	logic [CHAN_W-1:0] green_level;
	logic [CHAN_W-1:0] blue_level;

	modport source (output valid, output lamp_on, output red_level, output green_level,
		output blue_level, input ready);
	modport sink   (input valid, input lamp_on, input red_level, input green_level,
		input blue_level, output ready);
endinterface

interface irlc_cfg_if import irlc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ir_code_rgb_lamp_control.sv
// Top level of the IR-code RGB lamp control.
// Depends on irlc_pkg, irlc_if, irlc_regs, irlc_state and irlc_scale.
//
// Usage:
//   codes : valid/ready channel of decoded 32-bit remote button codes.
//   lamp  : valid/ready channel of results, one per accepted code: power flag
//           and the red, green and blue duty levels (zero while off).
//   cfg   : valid/ready write channel; index 0..2 set the toggle, color and
//           level codes, 3..5 the low, mid and high brightness percents.
//           Writes to other indexes are dropped. Write only while idle.
// Pipeline: a code passes the decode stage, the multiply stage and the
//   divide-and-saturate step into the result register.
// Throughput: one code per cycle unless stalled; the lamp state updates
//   at the transfer itself, so each code sees the state its predecessor left.
// Stall: a result held on lamp stalls the full stages behind it; bubbles in
//   the pipe still let new codes in, and ready drops only when all three
//   stages are full.
// Reset: arst_n clears power (off), color (white) and level (highest),
//   loads the default codes and percents; both sink channels hold ready low
//   until the first clock edge after reset release.
`timescale 1ns / 1ps
`default_nettype none

module ir_code_rgb_lamp_control import irlc_pkg::*; #(
	parameter int NUM_COLORS = 6,
	parameter int NUM_LEVELS = 3
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	irlc_code_if.sink  codes,
	irlc_lamp_if.source lamp,
	irlc_cfg_if.sink   cfg
);

	logic       run_q;
	cfg_t       cfg_regs;
	logic       valid_s1;
	scale_req_t req_s1;
	logic       scale_ready;
	rgb_t       lamp_rgb;

	// Hold both sinks off until run_q has been set after reset release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign cfg.ready = run_q;

	irlc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && run_q),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// Decode the code, advance the lamp state, and latch the new state.
	irlc_state #(
		.NUM_COLORS (NUM_COLORS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_regs),
		.in_valid   (codes.valid),
		.in_code    (codes.ir_code),
		.run        (run_q),
		.in_ready   (codes.ready),
		.valid_s1   (valid_s1),
		.req_s1     (req_s1),
		.down_ready (scale_ready)
	);

	// Scale each channel by the level percent and register the result.
	irlc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1),
		.up_ready  (scale_ready),
		.out_valid (lamp.valid),
		.out_ready (lamp.ready),
		.out_on    (lamp.lamp_on),
		.out_rgb   (lamp_rgb)
	);

	assign lamp.red_level   = lamp_rgb.red;
	assign lamp.green_level = lamp_rgb.green;
	assign lamp.blue_level  = lamp_rgb.blue;

endmodule

`default_nettype wire

// File: rtl/irlc_regs.sv
// Configuration register file: button codes and the three brightness percents.
// Depends on irlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irlc_regs import irlc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.toggle_code <= TOGGLE_CODE_RST;
			cfg_q.color_code  <= COLOR_CODE_RST;
			cfg_q.level_code  <= LEVEL_CODE_RST;
			cfg_q.pct_low     <= PCT_LOW_RST;
			cfg_q.pct_mid     <= PCT_MID_RST;
			cfg_q.pct_high    <= PCT_HIGH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TOGGLE_CODE: cfg_q.toggle_code <= wr_data;
				REG_COLOR_CODE:  cfg_q.color_code  <= wr_data;
				REG_LEVEL_CODE:  cfg_q.level_code  <= wr_data;
				REG_PCT_LOW:     cfg_q.pct_low     <= wr_data[PCT_W-1:0];
				REG_PCT_MID:     cfg_q.pct_mid     <= wr_data[PCT_W-1:0];
				REG_PCT_HIGH:    cfg_q.pct_high    <= wr_data[PCT_W-1:0];
				default: ; // drop writes past the last register
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/irlc_state.sv
// Code decode and lamp state (power, color index, level index), plus the first pipe stage.
// Depends on irlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irlc_state import irlc_pkg::*; #(
	parameter int NUM_COLORS = 6,
	parameter int NUM_LEVELS = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	input  wire logic [CODE_W-1:0] in_code,
	input  wire logic              run,
	output logic                   in_ready,
	output logic                   valid_s1,
	output scale_req_t             req_s1,
	input  wire logic              down_ready
);

	localparam logic [3:0] NCOL = 4'(NUM_COLORS);
	localparam logic [2:0] NLEV = 3'(NUM_LEVELS);
	localparam logic [1:0] LEVEL_RST = 2'(NUM_LEVELS - 1);

	logic       power_q;
	logic [2:0] color_q;
	logic [1:0] level_q;

	logic       power_d;
	logic [2:0] color_d;
	logic [1:0] level_d;
	logic [2:0] color_inc;
	logic [1:0] level_inc;
	logic [PCT_W-1:0] pct_d;
	logic       en_s1;
	logic       acc;

	// Stage 1 moves when empty or when stage 2 takes its item.
	assign en_s1    = !valid_s1 || down_ready;
	assign in_ready = en_s1 && run;
	assign acc      = in_valid && in_ready;

	assign color_inc = color_q + 3'd1;
	assign level_inc = level_q + 2'd1;

	always_comb begin
		power_d = power_q;
		color_d = color_q;
		level_d = level_q;
		priority if (in_code == cfg.toggle_code) begin
			power_d = !power_q;
		end else if (in_code == cfg.color_code) begin
			if (power_q) begin
				color_d = ({1'b0, color_inc} >= NCOL) ? 3'd0 : color_inc;
			end
		end else if (in_code == cfg.level_code) begin
			if (power_q) begin
				level_d = ({1'b0, level_inc} >= NLEV) ? 2'd0 : level_inc;
			end
		end else begin
			// unmatched code: hold the lamp state
		end
	end

	always_comb begin
		unique case (level_d)
			2'd0: pct_d = cfg.pct_low;
			2'd1: pct_d = cfg.pct_mid;
			2'd2: pct_d = cfg.pct_high;
			default: pct_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q  <= 1'b0;
			color_q  <= 3'd0;
			level_q  <= LEVEL_RST;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				power_q <= power_d;
				color_q <= color_d;
				level_q <= level_d;
			end
			if (en_s1) begin
				valid_s1 <= acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1.power <= power_d;
			req_s1.base  <= color_rgb(color_d);
			req_s1.pct   <= pct_d;
		end
	end

	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, color_q} < NCOL)
		else $error("color index out of range");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, level_q} < NLEV)
		else $error("level index out of range");

	a_power_only_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (in_code != cfg.toggle_code) |=> power_q == $past(power_q))
		else $error("power changed without toggle code");

	a_off_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !power_q |=> (color_q == $past(color_q)) && (level_q == $past(level_q)))
		else $error("color or level advanced while off");

endmodule

`default_nettype wire

// File: rtl/irlc_scale.sv
// Channel scaling pipe: base * percent, then divide by 100 with saturation (zero while off), into the result register.
// Depends on irlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irlc_scale import irlc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s1,
	input  wire scale_req_t req_s1,
	output logic            up_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_on,
	output rgb_t            out_rgb
);

	localparam int FULL_W = PROD_W + RECIP_W - 1;

	logic              valid_s2;
	logic              power_s2;
	logic [PROD_W-1:0] prod_r_s2;
	logic [PROD_W-1:0] prod_g_s2;
	logic [PROD_W-1:0] prod_b_s2;
	logic              out_valid_q;
	logic              out_on_q;
	rgb_t              out_rgb_q;
	logic              adv_out;
	logic              en_s2;
	rgb_t              lvl;

	function automatic logic [CHAN_W-1:0] div100_sat(input logic [PROD_W-1:0] p,
			input logic on);
		logic [FULL_W-1:0] m;
		logic [QUOT_W-1:0] q;
		m = FULL_W'(p) * FULL_W'(RECIP_100);
		q = m[RECIP_SHIFT +: QUOT_W];
		if (!on) begin
			return '0;
		end
		return (q > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : q[CHAN_W-1:0];
	endfunction

	assign adv_out  = !out_valid_q || out_ready;
	assign en_s2    = !valid_s2 || adv_out;
	assign up_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && en_s2) begin
			power_s2  <= req_s1.power;
			prod_r_s2 <= PROD_W'(req_s1.base.red)   * PROD_W'(req_s1.pct);
			prod_g_s2 <= PROD_W'(req_s1.base.green) * PROD_W'(req_s1.pct);
			prod_b_s2 <= PROD_W'(req_s1.base.blue)  * PROD_W'(req_s1.pct);
		end
	end

	assign lvl.red   = div100_sat(prod_r_s2, power_s2);
	assign lvl.green = div100_sat(prod_g_s2, power_s2);
	assign lvl.blue  = div100_sat(prod_b_s2, power_s2);

	always_ff @(posedge clk) begin
		if (valid_s2 && adv_out) begin
			out_on_q  <= power_s2;
			out_rgb_q <= lvl;
		end
	end

	assign out_valid = out_valid_q;
	assign out_on    = out_on_q;
	assign out_rgb   = out_rgb_q;

endmodule

`default_nettype wire
